[sv/pem_pkg.sv]
// Shared types and constants for the Prewitt edge magnitude unit.
package pem_pkg;

  localparam int unsigned PixW = 8;
  localparam int unsigned RowW = 12;
  localparam int unsigned ColW = 10;
  localparam int unsigned CfgWW = 11;
  localparam int unsigned CfgHW = 13;
  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam logic [16:0] SatLimit = 17'd65280;

  // register indexes on the configuration port
  localparam logic [0:0] RegWidth = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  // one classified window, handed from the front end to the magnitude unit
  typedef struct packed {
    logic             interior;
    logic             border;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic [PixW-1:0]  pixel;
    logic signed [10:0] dx;
    logic signed [10:0] dy;
  } job_t;

  typedef enum logic [1:0] {
    BeIdle,
    BeSqrt,
    BeEmitInt,
    BeEmitBrd
  } be_state_e;

endpackage

[sv/pem_front.sv]
// Front end: line stores, 3x3 window, frame counters and gradient sums.
module pem_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [pem_pkg::PixW-1:0]  pixel_i,
  input  logic                      restart_i,
  input  logic [pem_pkg::CfgWW-1:0] width_i,
  input  logic [pem_pkg::CfgHW-1:0] height_i,
  output logic                      job_valid_o,
  output pem_pkg::job_t             job_o
);
  import pem_pkg::*;

  localparam int unsigned AW = $clog2(MaxWidth);
  localparam int unsigned WW = $clog2(MaxWidth + 1);

  logic [PixW-1:0] up_mem [MaxWidth];
  logic [PixW-1:0] mid_mem [MaxWidth];
  logic [PixW-1:0] win_q [3][3];
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_s;
  logic [ColW-1:0] col_s;
  logic [PixW-1:0] pix_s;
  logic            stg_q;
  logic [AW-1:0]   idx;
  logic [PixW-1:0] up_rd_q, mid_rd_q;
  logic [WW-1:0]   w_eff;
  logic [RowW:0]   h_eff;
  logic            last_col, last_row;

  always_comb begin
    if (width_i < 11'd3) w_eff = WW'(3);
    else if ({{(32-CfgWW){1'b0}}, width_i} > MaxWidth) w_eff = WW'(MaxWidth);
    else w_eff = WW'(width_i);
    if (height_i < 13'd3) h_eff = (RowW+1)'(3);
    else if (height_i > 13'(MaxHeight)) h_eff = (RowW+1)'(MaxHeight);
    else h_eff = height_i[RowW:0];
  end

  assign idx = AW'(col_q);
  assign last_col = ({{(32-ColW){1'b0}}, col_q} + 1) >= {{(32-WW){1'b0}}, w_eff};
  assign last_row = ({1'b0, row_q} + 1'b1) >= h_eff;

  // stage 1: read line stores, write back shifted column
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      up_rd_q <= up_mem[idx];
      mid_rd_q <= mid_mem[idx];
      up_mem[idx] <= mid_mem[idx];
      mid_mem[idx] <= pixel_i;
      pix_s <= pixel_i;
      row_s <= row_q;
      col_s <= col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      stg_q <= 1'b0;
    end else begin
      stg_q <= push_i;
      if (restart_i) begin
        row_q <= '0;
        col_q <= '0;
      end else if (push_i) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  // stage 2: shift window, form sums
  logic [PixW-1:0] nw [3][3];
  logic [9:0] below, above, left, right;
  logic [RowW:0] h_m1;
  logic [WW-1:0] w_m1;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nw[i][0] = win_q[i][1];
      nw[i][1] = win_q[i][2];
    end
    nw[0][2] = up_rd_q;
    nw[1][2] = mid_rd_q;
    nw[2][2] = pix_s;
    below = 10'(nw[2][0]) + 10'(nw[2][1]) + 10'(nw[2][2]);
    above = 10'(nw[0][0]) + 10'(nw[0][1]) + 10'(nw[0][2]);
    left  = 10'(nw[0][0]) + 10'(nw[1][0]) + 10'(nw[2][0]);
    right = 10'(nw[0][2]) + 10'(nw[1][2]) + 10'(nw[2][2]);
    h_m1 = h_eff - 1'b1;
    w_m1 = w_eff - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
      job_valid_o <= 1'b0;
    end else begin
      job_valid_o <= stg_q;
      if (stg_q) begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) win_q[i][j] <= nw[i][j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_q) begin
      job_o.interior <= (row_s >= 12'd2) && (col_s >= 10'd2);
      job_o.border <= (row_s == '0) || (col_s == '0) || ({1'b0, row_s} == h_m1)
                      || ({{(32-ColW){1'b0}}, col_s} == {{(32-WW){1'b0}}, w_m1});
      job_o.row <= row_s;
      job_o.col <= col_s;
      job_o.pixel <= pix_s;
      job_o.dx <= $signed({1'b0, below}) - $signed({1'b0, above});
      job_o.dy <= $signed({1'b0, left}) - $signed({1'b0, right});
    end
  end

endmodule

[sv/pem_queue.sv]
// Small job queue between front end and magnitude unit.
module pem_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  pem_pkg::job_t wdata_i,
  input  logic          rd_i,
  output pem_pkg::job_t rdata_o,
  output logic          empty_o,
  output logic          almost_full_o
);
  import pem_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  job_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;

  assign rdata_o = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);
  // two jobs may still be in flight in the front end
  assign almost_full_o = ({{(31-AW){1'b0}}, cnt_q} + 3) > Depth;

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr_i) - (AW+1)'(rd_i);
    end
  end

endmodule

[sv/pem_back.sv]
// Back end: bit-serial rounded square root and result sequencing.
module pem_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     job_empty_i,
  input  pem_pkg::job_t            job_i,
  output logic                     job_pop_o,
  input  logic                     pop_i,
  output logic                     empty_o,
  output logic [pem_pkg::RowW-1:0] out_row_o,
  output logic [pem_pkg::ColW-1:0] out_col_o,
  output logic [pem_pkg::PixW-1:0] value_o,
  output logic                     last_of_run_o
);
  import pem_pkg::*;

  be_state_e st_q, st_d;
  job_t job_q;
  logic [20:0] sum_q;
  logic [8:0] f_q;
  logic [7:0] bit_q;
  logic [7:0] mag;
  logic [8:0] t;
  logic [17:0] tt;
  logic [20:0] ffp;
  logic signed [21:0] dx_sq, dy_sq;

  // signed squares, sign-extended by the 22-bit context
  assign dx_sq = job_i.dx * job_i.dx;
  assign dy_sq = job_i.dy * job_i.dy;

  always_comb begin
    t = f_q | {1'b0, bit_q};
    tt = t * t;
    ffp = 21'(f_q) * 21'(f_q) + 21'(f_q);
    if (sum_q > 21'(SatLimit)) mag = 8'hFF;
    else if (sum_q > ffp) mag = 8'(f_q + 1'b1);
    else mag = f_q[7:0];
  end

  always_comb begin
    st_d = st_q;
    job_pop_o = 1'b0;
    empty_o = 1'b1;
    out_row_o = job_q.row;
    out_col_o = job_q.col;
    value_o = job_q.pixel;
    last_of_run_o = 1'b1;
    case (st_q)
      BeIdle: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          if (job_i.interior) st_d = BeSqrt;
          else if (job_i.border) st_d = BeEmitBrd;
        end
      end
      BeSqrt: if (bit_q == 8'd1) st_d = BeEmitInt;
      BeEmitInt: begin
        empty_o = 1'b0;
        out_row_o = job_q.row - 1'b1;
        out_col_o = job_q.col - 1'b1;
        value_o = mag;
        last_of_run_o = !job_q.border;
        if (pop_i) st_d = job_q.border ? BeEmitBrd : BeIdle;
      end
      BeEmitBrd: begin
        empty_o = 1'b0;
        if (pop_i) st_d = BeIdle;
      end
      default: st_d = BeIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= BeIdle;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
      sum_q <= 21'(dx_sq) + 21'(dy_sq);
      f_q <= '0;
      bit_q <= 8'h80;
    end else if (st_q == BeSqrt) begin
      if (21'(tt) <= sum_q) f_q <= t;
      bit_q <= bit_q >> 1;
    end
  end

endmodule

[sv/prewitt_edge_magnitude_unit.sv]
// Prewitt edge magnitude unit: APB registers, front end, job queue, back end.
// Pixels enter in raster order through push/full; results leave through
// empty/pop with their row and column. Lines up to 1024 pixels wide. For an
// interior pixel the back end loads the job, finds the eight root bits one
// by one and presents the result, then a border copy if the pixel is also
// on the border; a border-only pixel is loaded and presented, and one with
// no result is only loaded. Pop low while a result waits stalls the back
// end. The front end registers each job in its line-store read and window
// stages; full rises once two jobs wait in the queue. Line stores need no clearing after reset.
module prewitt_edge_magnitude_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [pem_pkg::PixW-1:0]   pixel_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [pem_pkg::RowW-1:0]   out_row_o,
  output logic [pem_pkg::ColW-1:0]   out_col_o,
  output logic [pem_pkg::PixW-1:0]   value_o,
  output logic                       last_of_run_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import pem_pkg::*;

  logic [CfgWW-1:0] width_q;
  logic [CfgHW-1:0] height_q;
  logic wr, restart, acc;
  logic jv, jpop, jempty, afull;
  job_t jin, jout;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign restart = wr && (paddr[1:0] == 2'b00);
  assign full = afull;
  assign acc = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 11'd640;
      height_q <= 13'd480;
    end else if (restart) begin
      if (paddr[2] == RegWidth) width_q <= pwdata[CfgWW-1:0];
      else height_q <= pwdata[CfgHW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegHeight) prdata = 32'(height_q);
      else prdata = 32'(width_q);
    end
  end

  pem_front u_front (
    .clk_i, .rst_ni, .push_i(acc), .pixel_i, .restart_i(restart),
    .width_i(width_q), .height_i(height_q), .job_valid_o(jv), .job_o(jin)
  );

  pem_queue #(.Depth(4)) u_queue (
    .clk_i, .rst_ni, .wr_i(jv), .wdata_i(jin), .rd_i(jpop), .rdata_o(jout),
    .empty_o(jempty), .almost_full_o(afull)
  );

  pem_back u_back (
    .clk_i, .rst_ni, .job_empty_i(jempty), .job_i(jout), .job_pop_o(jpop),
    .pop_i(pop), .empty_o(empty), .out_row_o, .out_col_o, .value_o,
    .last_of_run_o
  );

endmodule

[sv/pem_checker.sv]
// Port-level checks for the Prewitt edge magnitude unit, bound to the top.
module pem_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       last_of_run_o,
  input logic [7:0] value_o,
  input logic       pready
);
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(value_o))
    else $error("result changed while stalled");
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && !last_of_run_o |=> !empty)
    else $error("second result of a pair missing");
endmodule

bind prewitt_edge_magnitude_unit pem_checker u_pem_checker (
  .clk_i, .rst_ni, .empty, .pop, .last_of_run_o, .value_o, .pready
);
